// File: src/vtpd_pkg.sv
// ----------------------------------------------------------------------------
// vtpd_pkg
// Shared types, constants and helpers for the vertex transform block.
// ----------------------------------------------------------------------------
package vtpd_pkg;

  localparam int NumRegs = 8;
  localparam int CfgIdxW = 8;
  localparam int SumW    = 50;
  localparam int MagW    = 48;
  localparam int RemW    = 64;
  localparam int QW      = 33;
  localparam int Lanes   = 3;

  localparam logic [31:0] QMax = 32'h7FFF_FFFF;
  localparam logic [31:0] QMin = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               w_was_zero;
  } out_t;

  typedef logic signed [31:0] entry_t;
  typedef entry_t [3:0][3:0]  matrix_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [QW-1:0]   q;
    logic            neg;
    logic            ovf;
    logic [31:0]     pass;
  } lane_t;

  typedef struct packed {
    logic                 valid;
    logic                 wzero;
    logic [MagW-1:0]      div;
    lane_t [Lanes-1:0]    lane;
  } cell_t;

  function automatic logic [31:0] sat32(input logic signed [SumW-1:0] s);
    logic [31:0] r;
    if (s > $signed({{(SumW-32){1'b0}}, QMax})) r = QMax;
    else if (s < $signed({{(SumW-32){1'b1}}, QMin})) r = QMin;
    else r = s[31:0];
    return r;
  endfunction

  function automatic logic [MagW-1:0] mag(input logic signed [SumW-1:0] s);
    logic [SumW-1:0] a;
    a = s[SumW-1] ? (~s + 1'b1) : s;
    return a[MagW-1:0];
  endfunction

endpackage

// File: src/vtpd_front.sv
// ----------------------------------------------------------------------------
// vtpd_front
// Products, column sums and divider setup; three stages.
// ----------------------------------------------------------------------------
module vtpd_front
  import vtpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_ok,
  input  in_t     in_data,
  input  matrix_t m,
  output cell_t   head
);

  logic signed [63:0]     prod [3][4];
  logic [1:0]             p_valid;
  logic signed [SumW-1:0] sum [4];
  logic signed [31:0]     pt [3];
  cell_t                  head_next;

  assign pt[0] = in_data.in_x;
  assign pt[1] = in_data.in_y;
  assign pt[2] = in_data.in_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= '0;
    end else if (en) begin
      p_valid <= {p_valid[0], in_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod[i][j] <= pt[i] * m[i][j];
        end
      end
      for (int j = 0; j < 4; j++) begin
        sum[j] <= SumW'(prod[0][j] >>> 16) + SumW'(prod[1][j] >>> 16)
                + SumW'(prod[2][j] >>> 16) + SumW'(m[3][j]);
      end
    end
  end

  always_comb begin
    logic [MagW-1:0] a;
    logic [MagW-1:0] b;
    b = mag(sum[3]);
    head_next.valid = p_valid[1];
    head_next.wzero = (sum[3] == '0);
    head_next.div   = b;
    for (int j = 0; j < Lanes; j++) begin
      a = mag(sum[j]);
      head_next.lane[j].rem  = {a, 16'b0};
      head_next.lane[j].q    = '0;
      head_next.lane[j].neg  = sum[j][SumW-1] ^ sum[3][SumW-1];
      head_next.lane[j].ovf  = {17'b0, a} >= {b, 17'b0};
      head_next.lane[j].pass = sat32(sum[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (en) begin
      head.valid <= head_next.valid;
    end
    if (en) begin
      head.wzero <= head_next.wzero;
      head.div   <= head_next.div;
      head.lane  <= head_next.lane;
    end
  end

endmodule

// File: src/vtpd_cell.sv
// ----------------------------------------------------------------------------
// vtpd_cell
// One restoring-divide step: resolves quotient bit K for all lanes.
// ----------------------------------------------------------------------------
module vtpd_cell
  import vtpd_pkg::*;
#(
  parameter int K = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cell_t prev,
  output cell_t cur
);

  cell_t cur_next;

  always_comb begin
    logic [RemW-1:0] hi;
    cur_next = prev;
    for (int j = 0; j < Lanes; j++) begin
      hi = prev.lane[j].rem >> K;
      if (hi >= {{(RemW-MagW){1'b0}}, prev.div}) begin
        cur_next.lane[j].rem  = prev.lane[j].rem
                              - ({{(RemW-MagW){1'b0}}, prev.div} << K);
        cur_next.lane[j].q[K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      cur.valid <= cur_next.valid;
    end
    if (en) begin
      cur.wzero <= cur_next.wzero;
      cur.div   <= cur_next.div;
      cur.lane  <= cur_next.lane;
    end
  end

endmodule

// File: src/vertex_transform_perspective_divide_top.sv
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide_top
// 4x4 homogeneous point transform with perspective divide, Q16.16.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data) takes one point per request.
// Output channel (out_valid/out_stall/out_data) returns one result per point,
// in order. Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) loads the
// matrix, two Q16.16 entries per 64-bit register; cfg_ready is always high,
// and indexes beyond seven are dropped. Load config only while idle.
// The accepting edge loads the products; the sum, divider setup, 33 divide
// cells and the output register follow in order. Throughput: one point per
// cycle while the output is not stalled, set by the cell chain which resolves
// one quotient bit per cell with every stage advancing each cycle.
// When the receiver stalls with a result held, the whole pipe freezes and
// in_stall rises in the same cycle. Reset clears all valid bits and zeros
// the matrix.
// ----------------------------------------------------------------------------
module vertex_transform_perspective_divide_top
  import vtpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_t               out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [63:0] regs [NumRegs];
  matrix_t     m;
  logic        en;
  cell_t       chain [QW+1];
  out_t        out_next;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NumRegs; k++) regs[k] <= '0;
    end else if (cfg_valid && cfg_ready && cfg_index < CfgIdxW'(NumRegs)) begin
      regs[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      m[r][0] = regs[2*r][31:0];
      m[r][1] = regs[2*r][63:32];
      m[r][2] = regs[2*r+1][31:0];
      m[r][3] = regs[2*r+1][63:32];
    end
  end

  vtpd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_ok   (in_valid && !in_stall),
    .in_data (in_data),
    .m       (m),
    .head    (chain[0])
  );

  for (genvar g = 0; g < QW; g++) begin : g_cell
    vtpd_cell #(.K(QW-1-g)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (chain[g]),
      .cur  (chain[g+1])
    );
  end

  always_comb begin
    logic [31:0] v [Lanes];
    lane_t       l;
    for (int j = 0; j < Lanes; j++) begin
      l = chain[QW].lane[j];
      if (chain[QW].wzero) v[j] = l.pass;
      else if (l.neg) begin
        if (l.ovf || l.q > QW'(33'h8000_0000)) v[j] = QMin;
        else v[j] = 32'(~l.q + 1'b1);
      end else begin
        if (l.ovf || l.q > {1'b0, QMax}) v[j] = QMax;
        else v[j] = l.q[31:0];
      end
    end
    out_next.out_x      = v[0];
    out_next.out_y      = v[1];
    out_next.out_z      = v[2];
    out_next.w_was_zero = chain[QW].wzero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= chain[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled without a held result");
  a_tail_delivered: assert property (@(posedge clk) disable iff (rst)
    (en && chain[QW].valid) |=> out_valid)
    else $error("finished result lost at output");
  a_head_frozen: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(chain[0].valid))
    else $error("pipe advanced while output held");

endmodule

// File: dv/tb_vertex_transform_perspective_divide_top.sv
// ----------------------------------------------------------------------------
// tb_vertex_transform_perspective_divide_top
// Drives points through the 4x4 transform under several matrices and
// handshake pressure phases, predicting each result from a local fixed-point
// model of the multiply, sum, zero-w test, divide and saturation.
// ----------------------------------------------------------------------------
module tb_vertex_transform_perspective_divide_top;
  import vtpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RegCount = 8;
  localparam int Latency = 37;
  localparam logic [CfgIdxW-1:0] BadIndex = 8'd9;

  class transform_scoreboard;
    logic [63:0] mat_regs [RegCount];
    out_t pending [$];
    int errors;

    function new();
      foreach (mat_regs[k]) mat_regs[k] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
      if (idx < RegCount) mat_regs[idx] = val;
    endfunction

    function longint coef(int row, int col);
      logic [63:0] r;
      r = mat_regs[row * 2 + col / 2];
      return (col % 2) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
    endfunction

    function longint clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint scaled_quotient(longint s, longint w);
      logic neg;
      logic [63:0] a, b, q1, r, frac, m;
      neg = (s < 0) != (w < 0);
      a = s < 0 ? -s : s;
      b = w < 0 ? -w : w;
      q1 = a / b;
      r = a % b;
      frac = 0;
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        frac = frac << 1;
        if (r >= b) begin
          r = r - b;
          frac[0] = 1'b1;
        end
      end
      m = (q1 > 64'd65536) ? (64'd1 << 33) : ((q1 << 16) | frac);
      if (neg) return (m > 64'd2147483648) ? -64'sd2147483648 : -longint'(m);
      return (m > 64'd2147483647) ? 64'sd2147483647 : longint'(m);
    endfunction

    function void note_point(in_t p);
      longint v [3];
      longint acc [4];
      longint o [3];
      out_t e;
      v[0] = p.in_x;
      v[1] = p.in_y;
      v[2] = p.in_z;
      for (int j = 0; j < 4; j++) begin
        acc[j] = coef(3, j);
        for (int i = 0; i < 3; i++) acc[j] += (v[i] * coef(i, j)) >>> 16;
      end
      for (int j = 0; j < 3; j++)
        o[j] = (acc[3] == 0) ? clamp(acc[j]) : scaled_quotient(acc[j], acc[3]);
      e.out_x = o[0][31:0];
      e.out_y = o[1][31:0];
      e.out_z = o[2][31:0];
      e.w_was_zero = (acc[3] == 0);
      pending.push_back(e);
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.out_x !== e.out_x) begin
        $error("out_x exp %h got %h", e.out_x, got.out_x);
        errors++;
      end
      if (got.out_y !== e.out_y) begin
        $error("out_y exp %h got %h", e.out_y, got.out_y);
        errors++;
      end
      if (got.out_z !== e.out_z) begin
        $error("out_z exp %h got %h", e.out_z, got.out_z);
        errors++;
      end
      if (got.w_was_zero !== e.w_was_zero) begin
        $error("w_was_zero exp %b got %b", e.w_was_zero, got.w_was_zero);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  in_t in_data = '0;
  out_t out_data;
  logic cfg_valid = 0, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int send_idle = 0, recv_stall = 0;
  transform_scoreboard sb = new();

  vertex_transform_perspective_divide_top dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  task automatic write_matrix_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_point(in_t p);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    sb.note_point(p);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_entry(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(32'h0003_0000) - 32'h0001_8000;
      default: return {{12{1'($urandom_range(1))}}, 20'($urandom())};
    endcase
  endfunction

  function automatic in_t rand_point(int mode);
    in_t p;
    p.in_x = rand_entry(mode);
    p.in_y = rand_entry(mode);
    p.in_z = rand_entry(mode);
    return p;
  endfunction

  task automatic load_matrix(int mode);
    for (int k = 0; k < RegCount; k++)
      write_matrix_reg(CfgIdxW'(k), {rand_entry(mode), rand_entry(mode)});
  endtask

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [31:0] edges [6];
    in_t p;
    edges = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000};
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // reset matrix: all zero, w zero
    send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h1});
    drain();
    // identity with w=1, then extremes
    for (int k = 0; k < RegCount; k++) write_matrix_reg(CfgIdxW'(k), 64'h0);
    write_matrix_reg(0, 64'h0000_0000_0001_0000);
    write_matrix_reg(2, 64'h0001_0000_0000_0000);
    write_matrix_reg(5, 64'h0000_0000_0001_0000);
    write_matrix_reg(7, 64'h0001_0000_0000_0000);
    write_matrix_reg(BadIndex, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 6; i++) begin
      p.in_x = edges[i];
      p.in_y = edges[(i + 1) % 6];
      p.in_z = edges[(i + 3) % 6];
      send_point(p);
    end
    drain();
    // w from z: tiny w, zero w, negative w
    write_matrix_reg(5, 64'h0000_0001_0001_0000);
    write_matrix_reg(7, 64'h0000_0000_0000_0000);
    send_point('{32'h0001_0000, 32'h0002_0000, 32'h0});
    send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF});
    send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000});
    send_point('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    drain();
    for (int k = 0; k < RegCount; k++)
      write_matrix_reg(CfgIdxW'(k), 64'hFFFF_FFFF_FFFF_FFFF);
    send_point('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_point('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    drain();
    for (int k = 0; k < RegCount; k++)
      write_matrix_reg(CfgIdxW'(k), {32'h7FFF_FFFF, 32'h8000_0000});
    send_point('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 55; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 55; end
        default: begin send_idle = 37; recv_stall = 37; end
      endcase
      load_matrix(ph % 3);
      for (int n = 0; n < 210; n++) begin
        if (n == 100) begin
          in_valid <= 0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
        send_point(rand_point($urandom_range(2)));
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// File: files.f
src/vtpd_pkg.sv
src/vtpd_front.sv
src/vtpd_cell.sv
src/vertex_transform_perspective_divide_top.sv
dv/tb_vertex_transform_perspective_divide_top.sv
